>>> rtl/ppu_pkg.sv
// Shared types and constants for the packed pixel unpacker.
package ppu_pkg;

  localparam int unsigned CfgIndexW = 32;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CFG_BITS_PER_PIXEL = 32'd0;
  localparam logic [CfgIndexW-1:0] CFG_IMAGE_COLUMNS  = 32'd1;
  localparam logic [CfgIndexW-1:0] CFG_IMAGE_ROWS     = 32'd2;

  localparam logic [3:0]  BPP_RESET  = 4'd8;
  localparam logic [15:0] SIZE_RESET = 16'd1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic byte_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/ppu_ctrl.sv
// Controller: accepts a byte, then steps the datapath until the byte is used up.
module ppu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppu_pkg::status_t stat,
  output ppu_pkg::cmd_t    cmd
);

  ppu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      ppu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ppu_pkg::ST_RUN;
        end
      end
      ppu_pkg::ST_RUN: begin
        // hold while a finished pixel has nowhere to go
        cmd.step = !(stat.complete && !stat.out_free);
        if (cmd.step && stat.byte_done) begin
          state_next = ppu_pkg::ST_IDLE;
        end
      end
      default: state_next = ppu_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/ppu_datapath.sv
// Datapath: config registers, bit extraction, position counters, output register.
module ppu_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ppu_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [ppu_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [7:0]                      data_byte,
  input  ppu_pkg::cmd_t                   cmd,
  output ppu_pkg::status_t                stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      pixel_value,
  output logic                            end_of_row,
  output logic                            end_of_image,
  output logic                            last
);

  logic [3:0]  reg_bpp;
  logic [15:0] reg_cols;
  logic [15:0] reg_rows;

  logic [7:0]  byte_reg;
  logic [3:0]  pos;
  logic [7:0]  partial;
  logic [2:0]  bits_held;
  logic [15:0] col;
  logic [15:0] row;

  logic [3:0]  bpp;
  logic [15:0] cols;
  logic [15:0] rows;
  logic [3:0]  need;
  logic [3:0]  avail;
  logic [3:0]  take;
  logic [7:0]  shifted;
  logic [7:0]  mask;
  logic [15:0] wide;
  logic [7:0]  partial_next;
  logic [3:0]  held_next;
  logic [3:0]  pos_next;
  logic [3:0]  remain;
  logic        complete;
  logic        eor;
  logic        eoi;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_bpp  <= ppu_pkg::BPP_RESET;
      reg_cols <= ppu_pkg::SIZE_RESET;
      reg_rows <= ppu_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ppu_pkg::CFG_BITS_PER_PIXEL: reg_bpp  <= cfg_data[3:0];
        ppu_pkg::CFG_IMAGE_COLUMNS:  reg_cols <= cfg_data;
        ppu_pkg::CFG_IMAGE_ROWS:     reg_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bpp = reg_bpp;
    if (reg_bpp == 4'd0) bpp = 4'd1;
    if (reg_bpp > 4'd8)  bpp = 4'd8;
    cols = (reg_cols == 16'd0) ? 16'd1 : reg_cols;
    rows = (reg_rows == 16'd0) ? 16'd1 : reg_rows;

    need         = bpp - {1'b0, bits_held};
    avail        = 4'd8 - pos;
    take         = (need < avail) ? need : avail;
    shifted      = byte_reg >> (avail - take);
    mask         = 8'((9'd1 << take) - 9'd1);
    wide         = {8'd0, partial} << take;
    partial_next = wide[7:0] | (shifted & mask);
    held_next    = {1'b0, bits_held} + take;
    pos_next     = pos + take;
    remain       = 4'd8 - pos_next;
    complete     = (held_next == bpp);
    eor          = ({1'b0, col} + 17'd1) >= {1'b0, cols};
    eoi          = eor && (({1'b0, row} + 17'd1) >= {1'b0, rows});
  end

  assign stat.complete  = complete;
  // a step that completes no pixel has taken the rest of the byte
  assign stat.byte_done = !complete || eoi || (pos_next == 4'd8);
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= 8'd0;
      bits_held <= 3'd0;
      col       <= 16'd0;
      row       <= 16'd0;
      pos       <= 4'd0;
    end else if (cmd.load) begin
      byte_reg <= data_byte;
      pos      <= 4'd0;
      // drop held bits that no longer fit the pixel width
      if ({1'b0, bits_held} >= bpp) begin
        bits_held <= 3'd0;
        partial   <= 8'd0;
      end
    end else if (cmd.step) begin
      pos <= pos_next;
      if (complete) begin
        partial   <= 8'd0;
        bits_held <= 3'd0;
        if (eoi) begin
          col <= 16'd0;
          row <= 16'd0;
        end else if (eor) begin
          col <= 16'd0;
          row <= row + 16'd1;
        end else begin
          col <= col + 16'd1;
        end
      end else begin
        partial   <= partial_next;
        bits_held <= held_next[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && complete) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && complete) begin
      pixel_value  <= partial_next;
      end_of_row   <= eor;
      end_of_image <= eoi;
      last         <= eoi || (remain < bpp);
    end
  end

endmodule

>>> rtl/packed_pixel_unpacker_top.sv
// Top level of the packed pixel unpacker.
//
// Input channel (in_valid / in_stall, data_byte) takes one byte of a
// bit-packed gray image, MSB first. Output channel (out_valid / out_stall)
// gives one item per completed pixel: pixel_value right aligned, with
// end_of_row, end_of_image and last (final pixel caused by this byte).
// Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 bits_per_pixel, 1 image_columns, 2 image_rows; other indexes are
// ignored. Write config only while the block is idle.
// After a byte is accepted, in_stall stays high while the datapath extracts
// one pixel field per cycle unless the output stalls: one field for each
// pixel the byte finishes, plus one if it ends on a partial pixel. The byte
// is held in byte_reg, and each finished pixel is registered in the output
// register. Out_stall holds the output register and freezes the extraction
// step until the pixel is taken.
// After the last pixel of an image the rest of the byte is dropped.
// Reset (rst, synchronous) clears the position state and output valid and
// restores bits_per_pixel 8, one column, one row.
module packed_pixel_unpacker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    pixel_value,
  output logic                          end_of_row,
  output logic                          end_of_image,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppu_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ppu_pkg::CfgDataW-1:0]  cfg_data
);

  ppu_pkg::cmd_t    cmd;
  ppu_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  ppu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .end_of_row   (end_of_row),
    .end_of_image (end_of_image),
    .last         (last)
  );

endmodule

>>> rtl/ppu_checker.sv
// Port-level checks for the packed pixel unpacker, bound to the top level.
module ppu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_value,
  input logic       end_of_row,
  input logic       end_of_image,
  input logic       last
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && out_valid && out_stall |=> out_valid && $stable(pixel_value) &&
      $stable(end_of_row) && $stable(end_of_image) && $stable(last))
    else $error("stalled output item changed");

  a_eoi_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> end_of_row)
    else $error("end of image without end of row");

  a_eoi_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> last)
    else $error("end of image not flagged as last of its byte");

  // an accepted byte keeps the input stalled while it is unpacked
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a byte was accepted");

endmodule

bind packed_pixel_unpacker_top ppu_checker u_ppu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_value  (pixel_value),
  .end_of_row   (end_of_row),
  .end_of_image (end_of_image),
  .last         (last)
);

>>> tb/testbench.sv
// Self-checking testbench for the packed pixel unpacker top level.
module testbench;

  localparam logic [ppu_pkg::CfgIndexW-1:0] CFG_UNUSED = 32'd3;
  localparam int unsigned RandomBytes = 420;
  localparam int unsigned BacklogCycles = 80;

  typedef struct packed {
    logic [7:0] value;
    logic       eor;
    logic       eoi;
    logic       last;
  } pixel_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_BYTE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [ppu_pkg::CfgIndexW-1:0]  index;
    logic [ppu_pkg::CfgDataW-1:0]   wdata;
    logic [7:0]                     data;
    logic                           typed;
    pixel_t                         want;
  } plan_row_t;

  localparam int PlanLen = 38;

  // Typed expectations only where the value is plain: bytes that finish a single pixel.
  localparam plan_row_t Plan [PlanLen] = '{
    '{ROW_BYTE,  '0, '0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{ROW_BYTE,  '0, '0, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
    '{ROW_BYTE,  '0, '0, 8'h5A, 1'b1, '{8'h5A, 1'b1, 1'b1, 1'b1}},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd1, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_COLUMNS,  16'd4, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_ROWS,     16'd2, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'hB6, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h6D, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd3, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_COLUMNS,  16'd3, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_ROWS,     16'hFFFF, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'hFF, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h81, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'hFFF0, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h3C, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'h000F, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'hC3, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd4, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_COLUMNS,  16'd0, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_ROWS,     16'd0, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h9E, 1'b1, '{8'h09, 1'b1, 1'b1, 1'b1}},
    '{ROW_WRITE, CFG_UNUSED,                  16'hFFFF, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'hE7, 1'b1, '{8'h0E, 1'b1, 1'b1, 1'b1}},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd7, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_COLUMNS,  16'hFFFF, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_ROWS,     16'hFFFF, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'hFF, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd1, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h80, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_BITS_PER_PIXEL, 16'd8, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h11, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h22, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h33, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_COLUMNS,  16'd2, 8'h00, 1'b0, '0},
    '{ROW_WRITE, ppu_pkg::CFG_IMAGE_ROWS,     16'd1, 8'h00, 1'b0, '0},
    '{ROW_BYTE,  '0, '0, 8'h44, 1'b1, '{8'h44, 1'b1, 1'b1, 1'b1}},
    '{ROW_BYTE,  '0, '0, 8'h55, 1'b1, '{8'h55, 1'b0, 1'b0, 1'b1}}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    data_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    pixel_value;
  logic                          end_of_row;
  logic                          end_of_image;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ppu_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [ppu_pkg::CfgDataW-1:0]  cfg_data = '0;

  // Side channel that travels with each byte: a typed expectation, if any.
  logic   byte_typed = 1'b0;
  pixel_t byte_want = '0;

  // Predictor copy of the registers and the unpacking state.
  logic [3:0]  width_reg;
  logic [15:0] cols_reg;
  logic [15:0] rows_reg;
  logic [7:0]  partial_bits;
  logic [3:0]  held_bits;
  logic [15:0] column_pos;
  logic [15:0] row_pos;

  pixel_t pixels_due [$];
  pixel_t unpacked [8];
  int     unpacked_n;
  int     mismatches = 0;

  logic steady = 1'b0;
  int   backlog_req = 0;

  packed_pixel_unpacker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .end_of_row   (end_of_row),
    .end_of_image (end_of_image),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Unpack one byte MSB first, return the pixels it completes.
  function automatic int unpack_byte(input logic [7:0] b, output pixel_t px [8]);
    logic [3:0] width;
    int         cols_eff;
    int         rows_eff;
    int         pos;
    int         need;
    int         take;
    int         n;
    logic [7:0] chunk;
    width = (width_reg == 4'd0) ? 4'd1 : (width_reg > 4'd8) ? 4'd8 : width_reg;
    cols_eff = (cols_reg == 16'd0) ? 1 : int'(cols_reg);
    rows_eff = (rows_reg == 16'd0) ? 1 : int'(rows_reg);
    n = 0;
    for (int k = 0; k < 8; k++) px[k] = '0;
    // drop held bits that no longer fit a narrower pixel
    if (held_bits >= width) begin
      held_bits = 4'd0;
      partial_bits = 8'h00;
    end
    pos = 0;
    while (pos < 8) begin
      need = int'(width) - int'(held_bits);
      take = (need < 8 - pos) ? need : 8 - pos;
      chunk = 8'((b >> (8 - pos - take)) & ((1 << take) - 1));
      partial_bits = 8'((partial_bits << take) | chunk);
      held_bits = held_bits + 4'(take);
      pos = pos + take;
      if (held_bits == width) begin
        px[n].value = partial_bits;
        px[n].eor = (int'(column_pos) + 1 >= cols_eff);
        px[n].eoi = px[n].eor && (int'(row_pos) + 1 >= rows_eff);
        px[n].last = 1'b0;
        partial_bits = 8'h00;
        held_bits = 4'd0;
        if (px[n].eoi) begin
          column_pos = 16'd0;
          row_pos = 16'd0;
          pos = 8;
        end else if (px[n].eor) begin
          column_pos = 16'd0;
          row_pos = row_pos + 16'd1;
        end else begin
          column_pos = column_pos + 16'd1;
        end
        n++;
      end
    end
    if (n > 0) px[n-1].last = 1'b1;
    return n;
  endfunction

  // Register writes, accepted bytes and emitted pixels, all seen at the rising edge.
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      width_reg = ppu_pkg::BPP_RESET;
      cols_reg = ppu_pkg::SIZE_RESET;
      rows_reg = ppu_pkg::SIZE_RESET;
      partial_bits = 8'h00;
      held_bits = 4'd0;
      column_pos = 16'd0;
      row_pos = 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppu_pkg::CFG_BITS_PER_PIXEL: width_reg = cfg_data[3:0];
          ppu_pkg::CFG_IMAGE_COLUMNS:  cols_reg = cfg_data;
          ppu_pkg::CFG_IMAGE_ROWS:     rows_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel value %02h eor %0b eoi %0b last %0b", $time,
                   pixel_value, end_of_row, end_of_image, last);
        end else begin
          want = pixels_due.pop_front();
          if ({pixel_value, end_of_row, end_of_image, last} !== want) begin
            mismatches++;
            $display("%0t: expected value %02h eor %0b eoi %0b last %0b, got %02h %0b %0b %0b",
                     $time, want.value, want.eor, want.eoi, want.last,
                     pixel_value, end_of_row, end_of_image, last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        unpacked_n = unpack_byte(data_byte, unpacked);
        if (byte_typed) pixels_due.push_back(byte_want);
        else for (int k = 0; k < unpacked_n; k++) pixels_due.push_back(unpacked[k]);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (backlog_req != hold_seen) begin
        hold_seen = backlog_req;
        hold_left = BacklogCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input pixel_t want);
    @(negedge clk);
    cfg_valid <= 1'b0;
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_typed <= typed;
    byte_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ppu_pkg::CfgIndexW-1:0] idx,
                           input logic [ppu_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain every pending pixel, then let a trailing partial byte finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic                          prev_byte;
    logic [3:0]                    width_pick;
    logic [15:0]                   size_pick;
    logic [ppu_pkg::CfgIndexW-1:0] bogus;
    int                            pick;
    int                            phase;
    int                            sent;
    int                            run_len;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    prev_byte = 1'b0;
    foreach (Plan[i]) begin
      if (Plan[i].kind == ROW_WRITE) begin
        if (prev_byte) wait_idle();
        cfg_write(Plan[i].index, Plan[i].wdata);
      end else begin
        send_byte(Plan[i].data, Plan[i].typed, Plan[i].want);
      end
      prev_byte = (Plan[i].kind == ROW_BYTE);
    end

    phase = 0;
    sent = 0;
    while (sent < RandomBytes) begin
      wait_idle();
      steady = (phase == 4);
      if (phase == 1 || $urandom_range(99) < 70) begin
        pick = $urandom_range(99);
        if (phase == 1) width_pick = 4'd1;
        else if (pick < 5) width_pick = 4'd0;
        else if (pick < 10) width_pick = 4'($urandom_range(9, 15));
        else if (pick < 20) width_pick = 4'd1;
        else if (pick < 30) width_pick = 4'd8;
        else width_pick = 4'($urandom_range(1, 8));
        cfg_write(ppu_pkg::CFG_BITS_PER_PIXEL, {12'($urandom()), width_pick});
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        size_pick = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hFFFF : 16'($urandom_range(1, 10));
        cfg_write(ppu_pkg::CFG_IMAGE_COLUMNS, size_pick);
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        size_pick = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hFFFF : 16'($urandom_range(1, 4));
        cfg_write(ppu_pkg::CFG_IMAGE_ROWS, size_pick);
      end
      if ($urandom_range(99) < 5) begin
        bogus = $urandom();
        if (bogus <= ppu_pkg::CFG_IMAGE_ROWS) bogus = CFG_UNUSED;
        cfg_write(bogus, 16'($urandom()));
      end
      // hold the receiver off while bytes keep coming
      if (phase == 1) backlog_req++;
      run_len = $urandom_range(12, 40);
      for (int k = 0; k < run_len; k++) begin
        send_byte(8'($urandom_range(255)), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && pixels_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
